FILE: sv/rv32x_pkg.sv
// Package for the RV32 subset instruction executor.
// Holds opcode and function codes, storage sizes and the execute-stage record.
// No dependencies.
package rv32x_pkg;

  // Storage sizes (DATA_WORDS must be a power of two)
  localparam int DATA_WORDS = 1024;
  localparam int REG_COUNT  = 32;
  localparam int DMEM_AW    = $clog2(DATA_WORDS);
  localparam int REG_AW     = $clog2(REG_COUNT);
  localparam int CLEAR_COUNT = (DATA_WORDS > REG_COUNT) ? DATA_WORDS : REG_COUNT;
  localparam int CLR_W      = $clog2(CLEAR_COUNT);

  // Major opcodes
  localparam logic [6:0] OP_RTYPE  = 7'b0110011;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_IARITH = 7'b0010011;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_JAL    = 7'b1101111;

  // R-type function codes
  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_SUB  = 7'b0100000;
  localparam logic [6:0] F7_MUL  = 7'b0000001;
  localparam logic [2:0] F3_ADD  = 3'b000;
  localparam logic [2:0] F3_AND  = 3'b111;
  localparam logic [2:0] F3_OR   = 3'b110;

  // Result of the execute stage, held while the item waits at the output
  typedef struct packed {
    logic [31:0]       pc;
    logic [31:0]       npc;
    logic              wr;
    logic [REG_AW-1:0] rd;
    logic [31:0]       wval;
    logic              is_load;
    logic              mw;
    logic [31:0]       maddr;
    logic [31:0]       mval;
  } exec_t;

endpackage

FILE: sv/rv32x_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Read data updates only when the read enable is high.
// No dependencies.
module rv32x_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/rv32_subset_instruction_executor_unit.sv
// Top level of the RV32 subset instruction executor.
// Uses rv32x_pkg and three rv32x_ram instances (two register file copies, data memory).
//
//   channel | dir | signals                 | item
//   s_axis  | in  | tvalid tready tdata[31:0]  | instruction_word
//   m_axis  | out | tvalid tready tdata[167:0] | executed_pc .. mem_value
//
// One instruction per cycle when the output is taken every cycle; each item passes
// the register file read register, then the execute and data memory register.
// After reset a clearing pass over CLEAR_COUNT (1024) addresses zeroes the data memory
// and register file; no item is accepted during it.
// A stall on the output freezes the whole pipe; register writes are forwarded from
// the output stage and from the write of the previous advance.
module rv32_subset_instruction_executor_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // [31:0] instruction_word
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] executed_pc, [63:32] next_pc, [64] reg_write, [69:65] reg_index,
  // [101:70] reg_value, [102] mem_write, [134:103] mem_address,
  // [166:135] mem_value, [167] zero
  output logic [167:0] m_axis_tdata
);
  import rv32x_pkg::*;

  // Pipe control
  logic             advance;
  logic             clearing;
  logic [CLR_W-1:0] clr_cnt;
  logic             s1_valid;
  logic [31:0]      s1_instr;
  logic             s2_valid;
  exec_t            s2;
  exec_t            exec_next;
  logic [31:0]      pc;

  // Last committed register write
  logic              w3_valid;
  logic [REG_AW-1:0] w3_rd;
  logic [31:0]       w3_val;

  // Memory ports
  logic [31:0]        rf_a_q, rf_b_q, dmem_q;
  logic               rf_we;
  logic [REG_AW-1:0]  rf_waddr;
  logic [31:0]        rf_wdata;
  logic               dm_we;
  logic [DMEM_AW-1:0] dm_waddr;
  logic [31:0]        dm_wdata;
  logic               dm_re;

  // Execute-stage decode
  logic [6:0]        opcode;
  logic [REG_AW-1:0] rd, rs1, rs2;
  logic [2:0]        f3;
  logic [6:0]        f7;
  logic [31:0]       a, b, s2_result, mul_lo;
  logic [31:0]       imm_i, imm_s, imm_b, imm_j;
  logic              wr_raw;
  logic [31:0]       wval_raw;

  assign advance       = !s2_valid || m_axis_tready;
  assign s_axis_tready = advance && !clearing;
  assign m_axis_tvalid = s2_valid;

  // Value written back by the item in the output stage
  assign s2_result = (s2.is_load && s2.wr) ? dmem_q : s2.wval;

  // Register file: two copies for two read ports, cleared after reset
  assign rf_we    = clearing || (advance && s2_valid && s2.wr);
  assign rf_waddr = clearing ? clr_cnt[REG_AW-1:0] : s2.rd;
  assign rf_wdata = clearing ? 32'd0 : s2_result;

  rv32x_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .re(advance), .raddr(s_axis_tdata[19:15]), .rdata(rf_a_q)
  );

  rv32x_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .re(advance), .raddr(s_axis_tdata[24:20]), .rdata(rf_b_q)
  );

  // Data memory: store writes and load reads both happen in execute order
  assign dm_we    = clearing || (advance && s1_valid && exec_next.mw);
  assign dm_waddr = clearing ? clr_cnt[DMEM_AW-1:0] : exec_next.maddr[2 +: DMEM_AW];
  assign dm_wdata = clearing ? 32'd0 : exec_next.mval;
  assign dm_re    = advance && s1_valid && exec_next.is_load;

  rv32x_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
    .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
    .re(dm_re), .raddr(exec_next.maddr[2 +: DMEM_AW]), .rdata(dmem_q)
  );

  // Field decode
  assign opcode = s1_instr[6:0];
  assign rd     = s1_instr[11:7];
  assign f3     = s1_instr[14:12];
  assign rs1    = s1_instr[19:15];
  assign rs2    = s1_instr[24:20];
  assign f7     = s1_instr[31:25];
  assign imm_i  = {{20{s1_instr[31]}}, s1_instr[31:20]};
  assign imm_s  = {{20{s1_instr[31]}}, s1_instr[31:25], s1_instr[11:7]};
  assign imm_b  = {{19{s1_instr[31]}}, s1_instr[31], s1_instr[7], s1_instr[30:25],
                   s1_instr[11:8], 1'b0};
  assign imm_j  = {{11{s1_instr[31]}}, s1_instr[31], s1_instr[19:12], s1_instr[20],
                   s1_instr[30:21], 1'b0};

  // Forward operands: output-stage write first, then the previous commit
  always_comb begin
    if (s2_valid && s2.wr && s2.rd == rs1) begin
      a = s2_result;
    end else if (w3_valid && w3_rd == rs1) begin
      a = w3_val;
    end else begin
      a = rf_a_q;
    end
    if (s2_valid && s2.wr && s2.rd == rs2) begin
      b = s2_result;
    end else if (w3_valid && w3_rd == rs2) begin
      b = w3_val;
    end else begin
      b = rf_b_q;
    end
  end

  assign mul_lo = a * b;

  // Execute
  always_comb begin
    exec_next         = '0;
    exec_next.pc      = pc;
    exec_next.npc     = pc + 32'd4;
    wr_raw            = 1'b0;
    wval_raw          = 32'd0;
    unique case (opcode)
      OP_RTYPE: begin
        wr_raw = 1'b1;
        if (f7 == F7_BASE && f3 == F3_ADD) begin
          wval_raw = a + b;
        end else if (f7 == F7_SUB && f3 == F3_ADD) begin
          wval_raw = a - b;
        end else if (f7 == F7_BASE && f3 == F3_AND) begin
          wval_raw = a & b;
        end else if (f7 == F7_BASE && f3 == F3_OR) begin
          wval_raw = a | b;
        end else if (f7 == F7_MUL && f3 == F3_ADD) begin
          wval_raw = mul_lo;
        end else begin
          wval_raw = 32'd0;
        end
      end
      OP_IARITH: begin
        wr_raw   = 1'b1;
        wval_raw = a + imm_i;
      end
      OP_LOAD: begin
        wr_raw            = 1'b1;
        exec_next.is_load = 1'b1;
        exec_next.maddr   = a + imm_i;
      end
      OP_STORE: begin
        exec_next.mw    = 1'b1;
        exec_next.maddr = a + imm_s;
        exec_next.mval  = b;
      end
      OP_BRANCH: begin
        if (a == b) begin
          exec_next.npc = pc + imm_b;
        end
      end
      OP_JAL: begin
        exec_next.npc = pc + imm_j;
      end
      default: begin
      end
    endcase
    // Drop writes to x0
    if (wr_raw && rd != '0) begin
      exec_next.wr   = 1'b1;
      exec_next.rd   = rd;
      exec_next.wval = wval_raw;
    end else begin
      exec_next.is_load = 1'b0;
    end
  end

  // Pipe registers, program counter and clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      w3_valid <= 1'b0;
      pc       <= 32'd0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == CLR_W'(CLEAR_COUNT - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (advance) begin
        s1_valid <= s_axis_tvalid && s_axis_tready;
        s2_valid <= s1_valid;
        w3_valid <= s2_valid && s2.wr;
        if (s1_valid) begin
          pc <= exec_next.npc;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_instr <= s_axis_tdata;
      s2       <= exec_next;
      w3_rd    <= s2.rd;
      w3_val   <= s2_result;
    end
  end

  // Pack the result item
  assign m_axis_tdata = {1'b0, s2.mval, s2.maddr, s2.mw, s2_result, s2.rd, s2.wr,
                         s2.npc, s2.pc};

endmodule
